### rtl/decimal_seven_segment_writer_core_defines.svh
// Assertion macros used by the checker file of the seven-segment writer.
`ifndef DECIMAL_SEVEN_SEGMENT_WRITER_CORE_DEFINES_SVH
`define DECIMAL_SEVEN_SEGMENT_WRITER_CORE_DEFINES_SVH

// A property that must hold at every clock edge outside of reset.
`define DSSW_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("%m: check failed");

// An implication: when the antecedent holds, the consequent holds too.
`define DSSW_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("%m: check failed");

// An implication whose consequent must hold at the next clock edge.
`define DSSW_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

### rtl/dssw_pkg.sv
// Types, constants and helper functions of the decimal seven-segment writer.
package dssw_pkg;

  // Field widths.
  localparam int ValueW = 32;
  localparam int OpW    = 2;
  localparam int AddrW  = 4;
  localparam int DataW  = 8;
  localparam int ScanW  = 3;
  localparam int CfgIdxW = 2;

  // Number of display digits driven, units digit at the highest address.
  localparam int DigitCount = 8;

  // Decimal digits needed to hold any value of the input width.
  localparam int BcdDigits = 10;
  localparam int BcdW      = 4 * BcdDigits;
  localparam int CntW      = $clog2(ValueW + 1);

  // Set-up words sent ahead of the digits.
  localparam int SetupCount = 5;
  localparam int IdxW = 3;

  // Operation codes.
  localparam logic [OpW-1:0] OpBlank = 2'd0;
  localparam logic [OpW-1:0] OpPad   = 2'd1;
  localparam logic [OpW-1:0] OpDot   = 2'd2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgIntensity = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgScan      = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgDecode    = 2'd2;

  // Driver register addresses.
  localparam logic [AddrW-1:0] AddrDecode    = 4'd9;
  localparam logic [AddrW-1:0] AddrIntensity = 4'd10;
  localparam logic [AddrW-1:0] AddrScan      = 4'd11;
  localparam logic [AddrW-1:0] AddrShutdown  = 4'd12;
  localparam logic [AddrW-1:0] AddrTest      = 4'd15;

  // Data constants.
  localparam logic [DataW-1:0] DotBit          = 8'h80;
  localparam logic [DataW-1:0] TestOffData     = 8'h00;
  localparam logic [DataW-1:0] NormalOpData    = 8'h01;
  localparam logic [DataW-1:0] BlankData       = 8'h00;
  localparam logic [DataW-1:0] IntensityReset  = 8'h2a;
  localparam logic [ScanW-1:0] ScanReset       = 3'd7;
  localparam logic [DataW-1:0] DecodeReset     = 8'h00;

  // Sequencer states.
  typedef enum logic [1:0] {
    StIdle,
    StConv,
    StSetup,
    StDigits
  } seq_state_e;

  // Commands from the sequencer to the converter.
  typedef struct packed {
    logic start;
    logic pop;
  } bcd_ctrl_t;

  // Status from the converter to the sequencer.
  typedef struct packed {
    logic       done;
    logic [3:0] digit;
    logic       rest_zero;
  } bcd_stat_t;

  // Segment pattern of one decimal digit.
  function automatic logic [DataW-1:0] seg_code(input logic [3:0] digit);
    logic [DataW-1:0] code;
    unique case (digit)
      4'd0:    code = 8'h7E;
      4'd1:    code = 8'h30;
      4'd2:    code = 8'h6D;
      4'd3:    code = 8'h79;
      4'd4:    code = 8'h33;
      4'd5:    code = 8'h5B;
      4'd6:    code = 8'h5F;
      4'd7:    code = 8'h70;
      4'd8:    code = 8'h7F;
      4'd9:    code = 8'h7B;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

endpackage

### rtl/dssw_if.sv
// Handshake channels of the seven-segment writer: input values and register writes.
interface dssw_in_if;
  import dssw_pkg::*;

  logic              valid;
  logic              ready;
  logic [ValueW-1:0] value;
  logic [OpW-1:0]    op;

  modport source (output valid, output value, output op, input ready);
  modport sink (input valid, input value, input op, output ready);
endinterface

interface dssw_out_if;
  import dssw_pkg::*;

  logic             valid;
  logic             ready;
  logic [AddrW-1:0] reg_addr;
  logic [DataW-1:0] reg_data;
  logic             last;

  modport source (output valid, output reg_addr, output reg_data, output last, input ready);
  modport sink (input valid, input reg_addr, input reg_data, input last, output ready);
endinterface

### rtl/dssw_bcd.sv
// Bit-serial binary to BCD converter with a digit shift-out port.
module dssw_bcd (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [dssw_pkg::ValueW-1:0]  value_i,
  input  dssw_pkg::bcd_ctrl_t          ctrl_i,
  output dssw_pkg::bcd_stat_t          stat_o
);
  import dssw_pkg::*;

  logic [ValueW-1:0] bin_q, bin_d;
  logic [BcdW-1:0]   bcd_q, bcd_d;
  logic [BcdW-1:0]   bcd_adj;
  logic [CntW-1:0]   cnt_q, cnt_d;

  // Add three to every digit of five or more ahead of the next shift.
  always_comb begin
    for (int i = 0; i < BcdDigits; i++) begin
      bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
                                                    : bcd_q[4*i +: 4];
    end
  end

  // Load, one bit per cycle while converting, then one digit out per pop.
  always_comb begin
    bin_d = bin_q;
    bcd_d = bcd_q;
    cnt_d = cnt_q;
    if (ctrl_i.start) begin
      bin_d = value_i;
      bcd_d = '0;
      cnt_d = CntW'(ValueW);
    end else if (cnt_q != '0) begin
      bcd_d = {bcd_adj[BcdW-2:0], bin_q[ValueW-1]};
      bin_d = {bin_q[ValueW-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
    end else if (ctrl_i.pop) begin
      bcd_d = {4'b0000, bcd_q[BcdW-1:4]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  // The units digit sits at the bottom; the rest tells whether more digits follow.
  assign stat_o.done      = (cnt_q == '0);
  assign stat_o.digit     = bcd_q[3:0];
  assign stat_o.rest_zero = (bcd_q[BcdW-1:4] == '0);

endmodule

### rtl/dssw_seq.sv
// Write sequencer: set-up words, digit words, configuration and output register.
module dssw_seq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dssw_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [dssw_pkg::DataW-1:0]    cfg_wdata_i,
  dssw_in_if.sink                       in_i,
  dssw_out_if.source                    out_o,
  output dssw_pkg::bcd_ctrl_t           bcd_ctrl_o,
  input  dssw_pkg::bcd_stat_t           bcd_stat_i
);
  import dssw_pkg::*;

  localparam logic [IdxW-1:0] SetupLast = IdxW'(SetupCount - 1);
  localparam logic [IdxW-1:0] DigitLast = IdxW'(DigitCount - 1);

  seq_state_e state_q, state_d;

  logic [DataW-1:0] intensity_q;
  logic [ScanW-1:0] scan_q;
  logic [DataW-1:0] decode_q;

  logic [IdxW-1:0]  idx_q, idx_d;
  logic             dotted_q, dotted_d;
  logic             pad_q, pad_d;
  logic             blank_q, blank_d;

  logic             out_valid_q, out_valid_d;
  logic [AddrW-1:0] addr_q, addr_d;
  logic [DataW-1:0] data_q, data_d;
  logic             last_q, last_d;

  logic             in_accept;
  logic             can_load;
  logic             load;

  assign in_accept = in_i.valid && in_i.ready;
  assign can_load  = !out_valid_q || out_o.ready;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      intensity_q <= IntensityReset;
      scan_q      <= ScanReset;
      decode_q    <= DecodeReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgIntensity: intensity_q <= cfg_wdata_i;
        CfgScan:      scan_q      <= cfg_wdata_i[ScanW-1:0];
        CfgDecode:    decode_q    <= cfg_wdata_i;
        default:      ;
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_accept) state_d = StConv;
      end
      StConv: begin
        if (bcd_stat_i.done) state_d = dotted_q ? StDigits : StSetup;
      end
      StSetup: begin
        if (can_load && idx_q == SetupLast) state_d = StDigits;
      end
      StDigits: begin
        if (can_load && idx_q == DigitLast) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // Outputs of the sequencer and the word to load.
  always_comb begin
    in_i.ready       = 1'b0;
    bcd_ctrl_o.start = 1'b0;
    bcd_ctrl_o.pop   = 1'b0;
    load             = 1'b0;
    idx_d            = idx_q;
    dotted_d         = dotted_q;
    pad_d            = pad_q;
    blank_d          = blank_q;
    addr_d           = addr_q;
    data_d           = data_q;
    last_d           = last_q;
    unique case (state_q)
      StIdle: begin
        in_i.ready = 1'b1;
        if (in_accept) begin
          bcd_ctrl_o.start = 1'b1;
          dotted_d         = in_i.op[1];
          pad_d            = (in_i.op == OpPad);
          blank_d          = 1'b0;
          idx_d            = '0;
        end
      end
      StConv: begin
        idx_d = '0;
      end
      StSetup: begin
        if (can_load) begin
          load   = 1'b1;
          last_d = 1'b0;
          idx_d  = (idx_q == SetupLast) ? '0 : idx_q + 1'b1;
          unique case (idx_q)
            3'd1: begin
              addr_d = AddrScan;
              data_d = {{(DataW-ScanW){1'b0}}, scan_q};
            end
            3'd2: begin
              addr_d = AddrDecode;
              data_d = decode_q;
            end
            3'd3: begin
              addr_d = AddrIntensity;
              data_d = intensity_q;
            end
            3'd4: begin
              addr_d = AddrShutdown;
              data_d = NormalOpData;
            end
            default: begin
              addr_d = AddrTest;
              data_d = TestOffData;
            end
          endcase
        end
      end
      StDigits: begin
        if (can_load) begin
          load           = 1'b1;
          bcd_ctrl_o.pop = 1'b1;
          addr_d         = AddrW'(DigitCount) - {{(AddrW-IdxW){1'b0}}, idx_q};
          data_d         = blank_q ? BlankData
                                   : (seg_code(bcd_stat_i.digit) | (dotted_q ? DotBit : '0));
          last_d         = (idx_q == DigitLast);
          blank_d        = blank_q || (bcd_stat_i.rest_zero && !pad_q);
          idx_d          = idx_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // The output register holds a word until the sink takes it.
  always_comb begin
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dotted_q <= dotted_d;
    pad_q    <= pad_d;
    blank_q  <= blank_d;
    addr_q   <= addr_d;
    data_q   <= data_d;
    last_q   <= last_d;
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.reg_addr = addr_q;
  assign out_o.reg_data = data_q;
  assign out_o.last     = last_q;

endmodule

### rtl/decimal_seven_segment_writer_core.sv
// Top level of the decimal seven-segment writer.
// Each input word (value, op) becomes a run of register writes for an eight-digit
// seven-segment driver: five set-up writes for ops 0 and 1, then eight digit writes
// from address 8 (units) down to address 1, with last set on the final one. The value
// is converted to decimal by a bit-serial shift-and-add-three unit, one bit per cycle.
// The writes stall while the output sink holds ready low. The block takes one item at a
// time; ready returns high once the last write is in the output register. Configuration
// registers (0 intensity, 1 scan limit, 2 decode setting) are written through cfg_we_i;
// the user must write them only while idle, and the block itself does not enforce this.
module decimal_seven_segment_writer_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dssw_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [dssw_pkg::DataW-1:0]    cfg_wdata_i,
  dssw_in_if.sink                       in_i,
  dssw_out_if.source                    out_o
);
  import dssw_pkg::*;

  bcd_ctrl_t bcd_ctrl;
  bcd_stat_t bcd_stat;

  // Converter: binary value to decimal digits, shifted out units first.
  dssw_bcd u_bcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .value_i (in_i.value),
    .ctrl_i  (bcd_ctrl),
    .stat_o  (bcd_stat)
  );

  // Sequencer: handshakes, set-up words, digit words.
  dssw_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_i),
    .out_o       (out_o),
    .bcd_ctrl_o  (bcd_ctrl),
    .bcd_stat_i  (bcd_stat)
  );

endmodule

### rtl/dssw_checker.sv
// Port-level checks of the seven-segment writer and their binding to the top level.
`include "decimal_seven_segment_writer_core_defines.svh"

module dssw_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [dssw_pkg::AddrW-1:0]  out_addr_i,
  input logic [dssw_pkg::DataW-1:0]  out_data_i,
  input logic                        out_last_i
);
  import dssw_pkg::*;

  // One item at a time: after an accept the input side stays closed.
  `DSSW_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i)

  // A stalled write keeps its contents.
  `DSSW_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_addr_i) && $stable(out_data_i) && $stable(out_last_i))

  // Only driver addresses in use appear.
  `DSSW_ASSERT_IMP(a_addr_legal, clk_i, rst_ni, out_valid_i, out_addr_i != 4'd0 && out_addr_i != 4'd13 && out_addr_i != 4'd14)

  // Every run ends on the leftmost digit.
  `DSSW_ASSERT_IMP(a_last_digit, clk_i, rst_ni, out_valid_i && out_last_i, out_addr_i == 4'd1)

endmodule

bind decimal_seven_segment_writer_core dssw_checker u_dssw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_addr_i  (out_o.reg_addr),
  .out_data_i  (out_o.reg_data),
  .out_last_i  (out_o.last)
);
